@@ sv/lzss_bit_decoder_assert.svh @@
// Assertion macros shared by the LZSS bit decoder modules.
`ifndef LZSS_BIT_DECODER_ASSERT_SVH
`define LZSS_BIT_DECODER_ASSERT_SVH

// Implication checked on every clock edge outside reset; expects clk and arst_n in scope.
`define LBD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Invariant checked on every clock edge outside reset.
`define LBD_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);

`endif

@@ sv/lbd_pkg.sv @@
// Shared constants, status codes and controller/datapath interface types.
package lbd_pkg;

	localparam int OFFSET_BITS_DEF = 13;
	localparam int LENGTH_BITS_DEF = 4;
	localparam int BYTE_W          = 8;
	localparam int SIZE_W          = 32;
	localparam int LEN_BIAS        = 3;
	localparam int MAX_RESULTS     = 19;
	localparam int RES_CNT_W       = $clog2(MAX_RESULTS + 1);

	typedef enum logic [1:0] {
		ST_RUNNING  = 2'd0,
		ST_OK       = 2'd1,
		ST_OVERFLOW = 2'd2,
		ST_MISMATCH = 2'd3
	} status_t;

	typedef struct packed {
		logic load;       // take the input request
		logic feed;       // consume one stream bit
		logic copy_rd;    // read one history byte for a match
		logic copy_emit;  // emit the history byte read by copy_rd
		logic flush;      // close out the request's results
	} lbd_cmd_t;

	typedef struct packed {
		logic finished;
		logic copy_pending;
		logic bits_avail;
		logic n_full;
		logic room;
		logic out_free;
	} lbd_sts_t;

endpackage

@@ sv/lbd_ctrl.sv @@
// Sequencing state machine for the LZSS bit decoder.
`include "lzss_bit_decoder_assert.svh"

module lbd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  lbd_pkg::lbd_sts_t sts,
	output lbd_pkg::lbd_cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_RUN   = 4'b0010,
		S_COPY  = 4'b0100,
		S_FLUSH = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_RUN;
				end
			end
			S_RUN: begin
				// match bytes go before stream bits; both stop at the per-request cap
				priority if (sts.finished) begin
					state_d = S_FLUSH;
				end else if (sts.copy_pending) begin
					if (sts.n_full) begin
						state_d = S_FLUSH;
					end else begin
						cmd.copy_rd = 1'b1;
						state_d     = S_COPY;
					end
				end else if (sts.n_full) begin
					state_d = S_FLUSH;
				end else if (sts.bits_avail) begin
					if (sts.room) begin
						cmd.feed = 1'b1;
					end
				end else begin
					state_d = S_FLUSH;
				end
			end
			S_COPY: begin
				if (sts.room) begin
					cmd.copy_emit = 1'b1;
					state_d       = S_RUN;
				end
			end
			S_FLUSH: begin
				if (sts.out_free) begin
					cmd.flush = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	`LBD_ASSERT_IMP(a_emit_has_room, cmd.feed || cmd.copy_emit, sts.room, "result without room")
	`LBD_ASSERT_IMP(a_flush_out_free, cmd.flush, sts.out_free, "flush into busy output")

endmodule

@@ sv/lbd_dp.sv @@
// Datapath: bit unpacking, token fields, history memory and result registers.
`include "lzss_bit_decoder_assert.svh"

module lbd_dp #(
	parameter int OFFSET_BITS = lbd_pkg::OFFSET_BITS_DEF,
	parameter int LENGTH_BITS = lbd_pkg::LENGTH_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  lbd_pkg::lbd_cmd_t                 cmd,
	output lbd_pkg::lbd_sts_t                 sts,
	input  logic [lbd_pkg::BYTE_W-1:0]        in_byte,
	input  logic                              in_final,
	input  logic                              cfg_we,
	input  logic [lbd_pkg::SIZE_W-1:0]        cfg_wdata,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [lbd_pkg::BYTE_W-1:0]        out_byte,
	output logic                              out_has,
	output logic                              out_last,
	output logic                              out_done,
	output lbd_pkg::status_t                  out_status
);

	localparam int DICT_DEPTH = 1 << OFFSET_BITS;
	localparam int GATH_W     = $clog2(OFFSET_BITS + 1);
	localparam int COPY_W     = LENGTH_BITS + 2;
	localparam int BW         = lbd_pkg::BYTE_W;
	localparam int SW         = lbd_pkg::SIZE_W;
	localparam int RW         = lbd_pkg::RES_CNT_W;

	typedef enum logic [3:0] {
		PH_FLAG = 4'b0001,
		PH_LIT  = 4'b0010,
		PH_OFF  = 4'b0100,
		PH_LEN  = 4'b1000
	} phase_t;

	logic [BW-1:0]          history [DICT_DEPTH];
	logic [BW-1:0]          rd_q;
	logic                   fill_ok_q;

	logic [SW-1:0]          decoded_size_q;
	logic                   started_q;
	logic                   finished_q;
	logic                   was_fin_q;
	logic                   tail_q;
	lbd_pkg::status_t       final_status_q;
	phase_t                 phase_q;
	logic [BW-1:0]          bit_buf_q;
	logic [3:0]             bits_left_q;
	logic [GATH_W-1:0]      gath_q;
	logic [OFFSET_BITS-1:0] acc_q;
	logic [OFFSET_BITS-1:0] copy_off_q;
	logic [COPY_W-1:0]      copy_left_q;
	logic [OFFSET_BITS-1:0] write_head_q;
	logic [SW-1:0]          emitted_q;
	logic [RW-1:0]          res_cnt_q;
	logic                   hold_v_q;
	logic [BW-1:0]          hold_byte_q;
	logic                   out_v_q;
	logic [BW-1:0]          out_byte_q;
	logic                   out_has_q;
	logic                   out_last_q;
	logic                   out_done_q;
	lbd_pkg::status_t       out_status_q;

	logic                   out_free, room;
	logic [3:0]             bl_m1;
	logic                   cur_bit;
	logic [OFFSET_BITS-1:0] acc_n;
	logic [GATH_W-1:0]      gath_n;
	logic                   lit_done, off_done, len_done;
	logic                   emit_req, emit_ovf, emit_ok, end_hit, push_hold, new_done;
	logic [BW-1:0]          emit_val;
	logic                   fill_ok;
	logic                   fresh, fin_cur, tail_cur, bl_cur_nz, cl_cur_nz, fin_eff;

	assign out_free = !out_v_q || out_ready;
	assign room     = !hold_v_q || out_free;

	assign bl_m1   = bits_left_q - 4'd1;
	assign cur_bit = (bits_left_q != 4'd0) ? bit_buf_q[bl_m1[2:0]] : 1'b0;
	assign acc_n   = {acc_q[OFFSET_BITS-2:0], cur_bit};
	assign gath_n  = gath_q + GATH_W'(1);

	assign lit_done = (phase_q == PH_LIT) && (gath_n >= GATH_W'(BW));
	assign off_done = (phase_q == PH_OFF) && (gath_n >= GATH_W'(OFFSET_BITS));
	assign len_done = (phase_q == PH_LEN) && (gath_n >= GATH_W'(LENGTH_BITS));

	assign emit_req  = (cmd.feed && lit_done) || cmd.copy_emit;
	assign emit_val  = cmd.copy_emit ? (fill_ok_q ? rd_q : '0) : acc_n[BW-1:0];
	assign emit_ovf  = emitted_q >= decoded_size_q;
	assign emit_ok   = emit_req && !emit_ovf;
	assign end_hit   = cmd.feed && off_done && (acc_n == '0);
	assign push_hold = emit_ok && hold_v_q;
	assign new_done  = finished_q && !was_fin_q;

	// entries 1..n are written after n bytes; entry 0 only once the head has wrapped
	assign fill_ok = (emitted_q[SW-1:OFFSET_BITS] != '0) ||
		((copy_off_q != '0) && (copy_off_q <= emitted_q[OFFSET_BITS-1:0]));

	// stream state as seen by a request; a closed stream reopens on it
	assign fresh     = !started_q;
	assign fin_cur   = started_q && finished_q;
	assign tail_cur  = started_q && tail_q;
	assign bl_cur_nz = started_q && (bits_left_q != 4'd0);
	assign cl_cur_nz = started_q && (copy_left_q != '0);
	assign fin_eff   = fin_cur || (fresh && (decoded_size_q == '0));

	always_ff @(posedge clk) begin
		if (emit_ok) begin
			history[write_head_q] <= emit_val;
		end
		if (cmd.copy_rd) begin
			rd_q <= history[copy_off_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decoded_size_q <= '0;
			started_q      <= 1'b0;
			finished_q     <= 1'b0;
			was_fin_q      <= 1'b0;
			tail_q         <= 1'b0;
			final_status_q <= lbd_pkg::ST_RUNNING;
			phase_q        <= PH_FLAG;
			bit_buf_q      <= '0;
			bits_left_q    <= 4'd0;
			gath_q         <= '0;
			acc_q          <= '0;
			copy_off_q     <= '0;
			copy_left_q    <= '0;
			write_head_q   <= OFFSET_BITS'(1);
			emitted_q      <= '0;
			res_cnt_q      <= '0;
			fill_ok_q      <= 1'b0;
			hold_v_q       <= 1'b0;
			hold_byte_q    <= '0;
			out_v_q        <= 1'b0;
			out_byte_q     <= '0;
			out_has_q      <= 1'b0;
			out_last_q     <= 1'b0;
			out_done_q     <= 1'b0;
			out_status_q   <= lbd_pkg::ST_RUNNING;
		end else begin
			if (cfg_we) begin
				decoded_size_q <= cfg_wdata;
			end

			if (cmd.load) begin
				res_cnt_q <= '0;
				started_q <= 1'b1;
				was_fin_q <= fin_cur;
				if (fresh) begin
					write_head_q   <= OFFSET_BITS'(1);
					phase_q        <= PH_FLAG;
					gath_q         <= '0;
					acc_q          <= '0;
					copy_off_q     <= '0;
					copy_left_q    <= '0;
					emitted_q      <= '0;
					finished_q     <= 1'b0;
					final_status_q <= lbd_pkg::ST_RUNNING;
					bits_left_q    <= 4'd0;
					tail_q         <= 1'b0;
				end
				if (fresh && (decoded_size_q == '0)) begin
					finished_q     <= 1'b1;
					final_status_q <= lbd_pkg::ST_OK;
				end
				if (fin_eff) begin
					tail_q <= tail_cur || in_final;
				end else if (!tail_cur && !bl_cur_nz && !cl_cur_nz) begin
					bit_buf_q   <= in_byte;
					bits_left_q <= 4'd8;
					tail_q      <= in_final;
				end
				// otherwise earlier work is pending and the byte is dropped
			end

			if (cmd.feed) begin
				if (bits_left_q != 4'd0) begin
					bits_left_q <= bl_m1;
				end
				unique case (phase_q)
					PH_FLAG: begin
						phase_q <= cur_bit ? PH_LIT : PH_OFF;
						gath_q  <= '0;
						acc_q   <= '0;
					end
					PH_LIT: begin
						acc_q  <= acc_n;
						gath_q <= gath_n;
						if (lit_done) begin
							phase_q <= PH_FLAG;
						end
					end
					PH_OFF: begin
						acc_q  <= acc_n;
						gath_q <= gath_n;
						if (off_done) begin
							if (acc_n == '0) begin
								phase_q <= PH_FLAG;
							end else begin
								copy_off_q <= acc_n;
								phase_q    <= PH_LEN;
								gath_q     <= '0;
								acc_q      <= '0;
							end
						end
					end
					PH_LEN: begin
						acc_q  <= acc_n;
						gath_q <= gath_n;
						if (len_done) begin
							copy_left_q <= COPY_W'(acc_n[LENGTH_BITS-1:0]) +
								COPY_W'(lbd_pkg::LEN_BIAS);
							phase_q     <= PH_FLAG;
						end
					end
					default: begin
						phase_q <= PH_FLAG;
					end
				endcase
			end

			if (cmd.copy_rd) begin
				copy_off_q  <= copy_off_q + OFFSET_BITS'(1);
				copy_left_q <= copy_left_q - COPY_W'(1);
				fill_ok_q   <= fill_ok;
			end

			if (emit_ok) begin
				write_head_q <= write_head_q + OFFSET_BITS'(1);
				emitted_q    <= emitted_q + SW'(1);
				res_cnt_q    <= res_cnt_q + RW'(1);
				hold_byte_q  <= emit_val;
				hold_v_q     <= 1'b1;
			end

			// byte past the expected size: drop it and the rest of the match
			if (emit_req && emit_ovf) begin
				finished_q     <= 1'b1;
				final_status_q <= lbd_pkg::ST_OVERFLOW;
				copy_left_q    <= '0;
			end

			if (end_hit) begin
				finished_q     <= 1'b1;
				final_status_q <= (emitted_q == decoded_size_q) ?
					lbd_pkg::ST_OK : lbd_pkg::ST_MISMATCH;
				copy_left_q    <= '0;
			end

			// held byte goes out only once we know whether it closes the request
			if (push_hold) begin
				out_v_q      <= 1'b1;
				out_byte_q   <= hold_byte_q;
				out_has_q    <= 1'b1;
				out_last_q   <= 1'b0;
				out_done_q   <= 1'b0;
				out_status_q <= lbd_pkg::ST_RUNNING;
			end else if (cmd.flush && (hold_v_q || new_done)) begin
				out_v_q      <= 1'b1;
				out_byte_q   <= hold_v_q ? hold_byte_q : '0;
				out_has_q    <= hold_v_q;
				out_last_q   <= 1'b1;
				out_done_q   <= new_done;
				out_status_q <= new_done ? final_status_q : lbd_pkg::ST_RUNNING;
				hold_v_q     <= 1'b0;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end

			if (cmd.flush && finished_q && tail_q) begin
				started_q <= 1'b0;
			end
		end
	end

	always_comb begin
		sts.finished     = finished_q;
		sts.copy_pending = copy_left_q != '0;
		sts.bits_avail   = (bits_left_q != 4'd0) || tail_q;
		sts.n_full       = res_cnt_q >= RW'(lbd_pkg::MAX_RESULTS);
		sts.room         = room;
		sts.out_free     = out_free;
	end

	assign out_valid  = out_v_q;
	assign out_byte   = out_byte_q;
	assign out_has    = out_has_q;
	assign out_last   = out_last_q;
	assign out_done   = out_done_q;
	assign out_status = out_status_q;

	`LBD_ASSERT_IMP(a_load_hold_empty, cmd.load, !hold_v_q, "request taken with byte held")
	`LBD_ASSERT_ALWAYS(a_head_tracks_count, write_head_q == OFFSET_BITS'(emitted_q[OFFSET_BITS-1:0] + OFFSET_BITS'(1)), "write head out of step")
	`LBD_ASSERT_ALWAYS(a_result_cap, res_cnt_q <= RW'(lbd_pkg::MAX_RESULTS), "result cap exceeded")

endmodule

@@ sv/lzss_bit_decoder.sv @@
// Top level of the LZSS bit decoder: controller plus datapath.
//
//  channel  dir  tdata           tuser                              tlast
//  s_*      in   packed_byte     -                                  final_byte
//  m_*      out  out_byte        has_byte, stream_done, status      last_of_run
//  cfg_*    in   decoded_size (write only, cfg_we strobe)
//
// The decoder works through each packed byte one stream bit at a time.
// Each match byte is a history memory read, then a write and emit.
// Taking in the request and closing out its results are separate steps.
// No clearing pass: a fill count masks history entries not yet written this stream.
// The output register lets the next request in while the last result waits;
// a stalled output stalls decoding once the one-byte hold stage is full.
module lzss_bit_decoder #(
	parameter int OFFSET_BITS = lbd_pkg::OFFSET_BITS_DEF,
	parameter int LENGTH_BITS = lbd_pkg::LENGTH_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [lbd_pkg::BYTE_W-1:0] s_tdata,   // [7:0] packed_byte
	input  logic                       s_tlast,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [lbd_pkg::BYTE_W-1:0] m_tdata,   // [7:0] out_byte
	output logic [3:0]                 m_tuser,   // [0] has_byte, [1] stream_done, [3:2] status
	output logic                       m_tlast,
	input  logic                       cfg_we,
	input  logic [lbd_pkg::SIZE_W-1:0] cfg_wdata
);

	lbd_pkg::lbd_cmd_t cmd;
	lbd_pkg::lbd_sts_t sts;
	logic              out_has;
	logic              out_done;
	lbd_pkg::status_t  out_status;

	lbd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lbd_dp #(
		.OFFSET_BITS (OFFSET_BITS),
		.LENGTH_BITS (LENGTH_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_byte    (s_tdata),
		.in_final   (s_tlast),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_byte   (m_tdata),
		.out_has    (out_has),
		.out_last   (m_tlast),
		.out_done   (out_done),
		.out_status (out_status)
	);

	assign m_tuser = {out_status, out_done, out_has};

endmodule

@@ tb/sv/tb_lzss_bit_decoder.sv @@
// Self-checking testbench for the LZSS bit decoder: stream encoder, decode predictor, checker.
`timescale 1ns / 100ps

module tb_lzss_bit_decoder;
	import lbd_pkg::*;

	localparam int OFF_W    = OFFSET_BITS_DEF;
	localparam int LEN_W    = LENGTH_BITS_DEF;
	localparam int HIST_LEN = 1 << OFF_W;
	localparam int DRAIN    = 80;
	localparam int WATCHDOG = 2000;

	typedef enum logic [1:0] {
		TK_FLAG,
		TK_LITERAL,
		TK_OFFSET,
		TK_LENGTH
	} token_phase_e;

	typedef struct {
		logic [7:0] data;
		logic       has;
		logic       done;
		status_t    st;
		logic       last;
	} dec_out_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = 8'h00;
	logic        s_tlast   = 1'b0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [7:0]  m_tdata;
	logic [3:0]  m_tuser;
	logic        m_tlast;
	logic        cfg_we    = 1'b0;
	logic [31:0] cfg_wdata = 32'h0;

	lzss_bit_decoder i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------- decode predictor ----------------
	logic [7:0]       hist [HIST_LEN];
	logic [OFF_W-1:0] wr_head;
	logic [OFF_W-1:0] src;
	token_phase_e     phase;
	int unsigned      nbits;
	logic [15:0]      acc;
	logic [31:0]      n_emitted;
	logic [31:0]      size_cfg;
	int unsigned      copy_cnt;
	logic [7:0]       cur_byte;
	int unsigned      cur_left;
	bit               done_flag;
	bit               tail_flag;
	bit               open_flag;
	status_t          end_status;

	dec_out_t step_q[$];
	dec_out_t want_q[$];

	int used_items   = 0;
	int results_seen = 0;
	int errors       = 0;
	int streams_sent = 0;
	int n_ok         = 0;
	int n_ovf        = 0;
	int n_mis        = 0;

	task automatic start_stream();
		foreach (hist[i]) hist[i] = 8'h00;
		wr_head    = 1;
		src        = '0;
		phase      = TK_FLAG;
		nbits      = 0;
		acc        = '0;
		n_emitted  = '0;
		copy_cnt   = 0;
		cur_byte   = '0;
		cur_left   = 0;
		done_flag  = 1'b0;
		tail_flag  = 1'b0;
		end_status = ST_RUNNING;
	endtask

	task automatic halt(input status_t code);
		done_flag  = 1'b1;
		end_status = code;
		copy_cnt   = 0;
	endtask

	task automatic put_byte(input logic [7:0] v);
		if (n_emitted >= size_cfg) begin
			halt(ST_OVERFLOW);
			return;
		end
		hist[wr_head] = v;
		wr_head       = wr_head + 1'b1;
		n_emitted     = n_emitted + 1;
		step_q.push_back('{v, 1'b1, 1'b0, ST_RUNNING, 1'b0});
	endtask

	task automatic take_bit(input logic b);
		if (phase == TK_FLAG) begin
			phase = b ? TK_LITERAL : TK_OFFSET;
			nbits = 0;
			acc   = '0;
		end else begin
			acc   = {acc[14:0], b};
			nbits = nbits + 1;
			if (phase == TK_LITERAL) begin
				if (nbits >= 8) begin
					phase = TK_FLAG;
					put_byte(acc[7:0]);
				end
			end else if (phase == TK_OFFSET) begin
				if (nbits >= OFF_W) begin
					if (acc == '0) begin
						// offset zero is the end marker
						phase = TK_FLAG;
						halt((n_emitted == size_cfg) ? ST_OK : ST_MISMATCH);
					end else begin
						src   = acc[OFF_W-1:0];
						phase = TK_LENGTH;
						nbits = 0;
						acc   = '0;
					end
				end
			end else if (nbits >= LEN_W) begin
				copy_cnt = acc + LEN_BIAS;
				phase    = TK_FLAG;
			end
		end
	endtask

	task automatic run_decoder();
		logic       b;
		logic [7:0] v;
		forever begin
			if (done_flag)
				break;
			if (copy_cnt > 0) begin
				if (step_q.size() >= MAX_RESULTS)
					break;
				v        = hist[src];
				src      = src + 1'b1;
				copy_cnt = copy_cnt - 1;
				put_byte(v);
				continue;
			end
			if (step_q.size() >= MAX_RESULTS)
				break;
			if (cur_left > 0) begin
				cur_left = cur_left - 1;
				b        = cur_byte[cur_left];
			end else if (tail_flag) begin
				b = 1'b0;   // zero fill after the final byte
			end else begin
				break;
			end
			take_bit(b);
		end
	endtask

	task automatic predict_request(input logic [7:0] pb, input logic fin);
		bit       fresh;
		bit       was_done;
		bit       loaded;
		dec_out_t tmp;
		fresh  = 1'b0;
		loaded = 1'b0;
		step_q.delete();
		if (!open_flag) begin
			start_stream();
			open_flag = 1'b1;
			fresh     = 1'b1;
		end
		was_done = done_flag;
		if (fresh && size_cfg == 0)
			halt(ST_OK);
		if (done_flag) begin
			if (fin)
				tail_flag = 1'b1;
		end else if (!tail_flag && cur_left == 0 && copy_cnt == 0) begin
			cur_byte  = pb;
			cur_left  = 8;
			tail_flag = fin;
			loaded    = 1'b1;
		end
		run_decoder();
		if (done_flag && !was_done) begin
			if (step_q.size() == 0)
				step_q.push_back('{8'h00, 1'b0, 1'b0, ST_RUNNING, 1'b0});
			tmp      = step_q[step_q.size()-1];
			tmp.done = 1'b1;
			tmp.st   = end_status;
			step_q[step_q.size()-1] = tmp;
			case (end_status)
				ST_OK:       n_ok++;
				ST_OVERFLOW: n_ovf++;
				default:     n_mis++;
			endcase
		end
		if (step_q.size() > 0) begin
			tmp      = step_q[step_q.size()-1];
			tmp.last = 1'b1;
			step_q[step_q.size()-1] = tmp;
		end
		if (done_flag && tail_flag)
			open_flag = 1'b0;
		if (loaded || step_q.size() > 0)
			used_items++;
		foreach (step_q[i]) want_q.push_back(step_q[i]);
	endtask

	task automatic check_result();
		dec_out_t w;
		results_seen++;
		if (want_q.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("ERROR: unexpected result byte %02h user %h last %b",
					m_tdata, m_tuser, m_tlast);
			return;
		end
		w = want_q.pop_front();
		if (m_tdata !== w.data || m_tuser[0] !== w.has || m_tuser[1] !== w.done ||
				m_tuser[3:2] !== w.st || m_tlast !== w.last) begin
			errors++;
			if (errors <= 10)
				$display({"ERROR: result %0d expected byte %02h has %b done %b status %0d ",
					"last %b, got byte %02h has %b done %b status %0d last %b"},
					results_seen, w.data, w.has, w.done, w.st, w.last,
					m_tdata, m_tuser[0], m_tuser[1], m_tuser[3:2], m_tlast);
		end
	endtask

	always @(posedge clk) begin
		if (s_tvalid && s_tready)
			predict_request(s_tdata, s_tlast);
		if (m_tvalid && m_tready)
			check_result();
	end

	// ---------------- idling ----------------
	bit tx_idle_on = 1'b1;
	bit rx_idle_on = 1'b1;
	int rx_hold    = 0;

	always @(negedge clk) begin
		if (rx_hold > 0) begin
			rx_hold--;
			m_tready <= 1'b0;
		end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
			rx_hold = $urandom_range(0, 11);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// ---------------- drive helpers ----------------
	task automatic send_packed(input logic [7:0] b, input logic fin);
		int gap;
		gap = 0;
		if (tx_idle_on && $urandom_range(0, 3) == 0)
			gap = $urandom_range(1, 12);
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= fin;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic tx_rest();
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	task automatic settle();
		tx_rest();
		while (want_q.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic set_size(input logic [31:0] v);
		settle();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
		size_cfg = v;
	endtask

	// ---------------- stream encoder ----------------
	bit sbits[$];
	int enc_count;

	task automatic begin_stream();
		sbits.delete();
		enc_count = 0;
	endtask

	task automatic put_field(input logic [15:0] value, input int n);
		for (int i = n - 1; i >= 0; i--) sbits.push_back(value[i]);
	endtask

	task automatic tok_literal(input logic [7:0] v);
		put_field(16'h1, 1);
		put_field(v, 8);
		enc_count++;
	endtask

	task automatic tok_match(input logic [OFF_W-1:0] off, input logic [LEN_W-1:0] len);
		put_field(16'h0, 1);
		put_field(off, OFF_W);
		put_field(len, LEN_W);
		enc_count += len + LEN_BIAS;
	endtask

	task automatic tok_end();
		put_field(16'h0, 1);
		put_field(16'h0, OFF_W);
	endtask

	// extra: bytes sent after the stream proper, the last of them final
	// hold_at: byte index before which the sender waits for all results
	task automatic ship_stream(input int extra, input int hold_at);
		int         nb;
		logic [7:0] b;
		nb = (sbits.size() + 7) / 8;
		if (nb == 0)
			nb = 1;
		streams_sent++;
		for (int k = 0; k < nb; k++) begin
			b = 8'h00;
			for (int j = 0; j < 8; j++)
				if (k * 8 + j < sbits.size())
					b[7-j] = sbits[k*8+j];
			if (k == hold_at) begin
				tx_rest();
				while (want_q.size() != 0) @(posedge clk);
			end
			send_packed(b, (k == nb - 1) && extra == 0);
		end
		for (int e = 0; e < extra; e++)
			send_packed($urandom_range(0, 255), e == extra - 1);
	endtask

	task automatic build_random_stream();
		int               ntok;
		int               d;
		logic [OFF_W-1:0] off;
		logic [LEN_W-1:0] len;
		begin_stream();
		ntok = $urandom_range(1, 10);
		for (int i = 0; i < ntok; i++) begin
			if ($urandom_range(0, 99) < 50) begin
				tok_literal($urandom_range(0, 255));
			end else begin
				if (enc_count > 0 && $urandom_range(0, 3) != 0) begin
					d   = $urandom_range(1, (enc_count < HIST_LEN - 1) ? enc_count : HIST_LEN - 1);
					off = 1 + enc_count - d;
				end else begin
					off = $urandom_range(1, HIST_LEN - 1);
				end
				len = ($urandom_range(0, 3) == 0) ? '1 : $urandom_range(0, (1 << LEN_W) - 1);
				tok_match(off, len);
			end
		end
		if ($urandom_range(0, 9) < 7)
			tok_end();
	endtask

	task automatic pick_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return;   // keep the current size, no write
		else if (r < 70)
			set_size(enc_count);
		else if (r < 82)
			set_size((enc_count > 0) ? $urandom_range(0, enc_count - 1) : 0);
		else if (r < 94)
			set_size(enc_count + $urandom_range(1, 20));
		else
			set_size($urandom());
	endtask

	// ---------------- tests ----------------
	task automatic test_empty_stream();
		set_size(0);
		send_packed(8'hA5, 1'b0);
		send_packed(8'hFF, 1'b0);   // ignored, stream already over
		send_packed(8'h00, 1'b1);   // ignored, closes the stream
		send_packed(8'h3C, 1'b1);   // fresh stream, empty again
		streams_sent += 2;
	endtask

	task automatic test_literals();
		begin_stream();
		tok_literal(8'h00);
		tok_literal(8'hFF);
		tok_literal(8'h80);
		tok_literal(8'h7F);
		tok_end();
		set_size(enc_count);
		ship_stream(0, -1);
	endtask

	task automatic test_matches();
		begin_stream();
		tok_literal(8'h11);
		tok_match(1, '1);          // overlapping run of the one literal
		tok_match('1, '1);         // top offset, wraps through unwritten entries
		tok_match(1, 0);           // shortest copy
		set_size(enc_count);       // no end marker: zero fill ends it
		ship_stream(0, 4);
	endtask

	task automatic test_overflow();
		begin_stream();
		tok_literal(8'hC3);
		tok_literal(8'h3C);
		tok_end();
		set_size(1);
		ship_stream(0, -1);
	endtask

	task automatic test_after_end();
		begin_stream();
		tok_literal(8'h01);
		tok_end();
		set_size(32'hFFFF_FFFF);
		ship_stream(1, -1);        // one byte after the end marker
	endtask

	task automatic test_random_streams();
		int k;
		k = 0;
		while (used_items < 200) begin
			build_random_stream();
			pick_size();
			ship_stream(($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0,
				(k % 7 == 3) ? $urandom_range(0, 2) : -1);
			k++;
		end
	endtask

	task automatic test_noise();
		int base;
		int sent;
		set_size($urandom_range(0, 40));
		base = used_items;
		sent = 0;
		while (used_items - base < 45 && sent < 400) begin
			if (sent == 200)
				set_size($urandom());
			send_packed($urandom_range(0, 255), $urandom_range(0, 7) == 0);
			sent++;
		end
	endtask

	task automatic test_quiet_finish();
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		settle();
		do begin
			build_random_stream();
			pick_size();
			ship_stream(0, -1);
		end while (used_items < 280);
	endtask

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout: no request moved for %0d cycles", WATCHDOG);
		$display("** lzss_bit_decoder: FAILED **");
		$finish;
	end

	initial begin
		start_stream();
		size_cfg  = '0;
		open_flag = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		test_empty_stream();
		test_literals();
		test_matches();
		test_overflow();
		test_after_end();
		test_random_streams();
		test_noise();
		test_quiet_finish();
		settle();

		$display("Covered %0d streams from %0d decoding requests, %0d results checked.",
			streams_sent, used_items, results_seen);
		$display("Stream ends seen: %0d ok, %0d overflow, %0d length mismatch; %0d errors.",
			n_ok, n_ovf, n_mis, errors);
		if (errors == 0 && want_q.size() == 0)
			$display("** lzss_bit_decoder: PASSED **");
		else
			$display("** lzss_bit_decoder: FAILED **");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+sv
sv/lbd_pkg.sv
sv/lbd_ctrl.sv
sv/lbd_dp.sv
sv/lzss_bit_decoder.sv
tb/sv/tb_lzss_bit_decoder.sv
